// ===== rtl/bftr_pkg.sv =====
// ----------------------------------------------------------------------------
// bftr_pkg
// Shared constants, types and the 4x6 font table for the text rasterizer.
// ----------------------------------------------------------------------------
package bftr_pkg;

	localparam int SCREEN_WIDTH  = 256;
	localparam int SCREEN_HEIGHT = 192;

	localparam int GLYPH_W    = 4;
	localparam int GLYPH_H    = 6;
	localparam int GLYPH_BITS = GLYPH_W * GLYPH_H;
	localparam int BIT_IDX_W  = $clog2(GLYPH_BITS);
	localparam int COL_W      = $clog2(GLYPH_W);

	localparam int COORD_W  = 12;
	localparam int PEN_STEP = 5;
	localparam int PEN_MAX  = 2047;
	// visible coordinates never exceed 2047
	localparam int VIS_W    = 11;

	localparam int CODE_W   = 8;
	localparam int COLOR_W  = 16;
	localparam int ADDR_W   = 16;
	localparam int PIX_W    = 8;

	localparam logic [CODE_W-1:0] CodeLowA  = 8'h61;
	localparam logic [CODE_W-1:0] CodeLowZ  = 8'h7A;
	localparam logic [CODE_W-1:0] CaseShift = 8'h20;

	typedef logic [GLYPH_H-1:0][GLYPH_W-1:0] glyph_t;

	// One character's work handed from the mask stage to the pixel scanner.
	typedef struct packed {
		logic [GLYPH_BITS-1:0]    mask;    // visible set bits, bit = row*4+col
		logic signed [COORD_W-1:0] base_x;
		logic signed [COORD_W-1:0] base_y;
		logic [COLOR_W-1:0]       color;
		logic                     screen;
	} glyph_item_t;

	function automatic glyph_t mk_glyph(input logic [3:0] r0, input logic [3:0] r1,
			input logic [3:0] r2, input logic [3:0] r3, input logic [3:0] r4);
		glyph_t g;
		g[0] = r0;
		g[1] = r1;
		g[2] = r2;
		g[3] = r3;
		g[4] = r4;
		g[5] = 4'h0;
		return g;
	endfunction

	// Bit 3 of a row is the leftmost column. Codes without a glyph are blank.
	function automatic glyph_t glyph_lookup(input logic [6:0] code);
		glyph_t g;
		case (code)
			7'h30:   g = mk_glyph(4'h6, 4'h9, 4'h9, 4'h9, 4'h6);
			7'h31:   g = mk_glyph(4'h2, 4'h6, 4'h2, 4'h2, 4'h7);
			7'h32:   g = mk_glyph(4'h6, 4'h9, 4'h2, 4'h4, 4'hF);
			7'h33:   g = mk_glyph(4'hE, 4'h1, 4'h6, 4'h1, 4'hE);
			7'h34:   g = mk_glyph(4'h9, 4'h9, 4'hF, 4'h1, 4'h1);
			7'h35:   g = mk_glyph(4'hF, 4'h8, 4'hE, 4'h1, 4'hE);
			7'h36:   g = mk_glyph(4'h6, 4'h8, 4'hE, 4'h9, 4'h6);
			7'h37:   g = mk_glyph(4'hF, 4'h1, 4'h2, 4'h4, 4'h4);
			7'h38:   g = mk_glyph(4'h6, 4'h9, 4'h6, 4'h9, 4'h6);
			7'h39:   g = mk_glyph(4'h6, 4'h9, 4'h7, 4'h1, 4'h6);
			7'h41:   g = mk_glyph(4'h6, 4'h9, 4'hF, 4'h9, 4'h9);
			7'h42:   g = mk_glyph(4'hE, 4'h9, 4'hE, 4'h9, 4'hE);
			7'h43:   g = mk_glyph(4'h7, 4'h8, 4'h8, 4'h8, 4'h7);
			7'h44:   g = mk_glyph(4'hE, 4'h9, 4'h9, 4'h9, 4'hE);
			7'h45:   g = mk_glyph(4'hF, 4'h8, 4'hE, 4'h8, 4'hF);
			7'h46:   g = mk_glyph(4'hF, 4'h8, 4'hE, 4'h8, 4'h8);
			7'h47:   g = mk_glyph(4'h7, 4'h8, 4'hB, 4'h9, 4'h7);
			7'h48:   g = mk_glyph(4'h9, 4'h9, 4'hF, 4'h9, 4'h9);
			7'h49:   g = mk_glyph(4'h7, 4'h2, 4'h2, 4'h2, 4'h7);
			7'h4A:   g = mk_glyph(4'h1, 4'h1, 4'h1, 4'h9, 4'h6);
			7'h4B:   g = mk_glyph(4'h9, 4'hA, 4'hC, 4'hA, 4'h9);
			7'h4C:   g = mk_glyph(4'h8, 4'h8, 4'h8, 4'h8, 4'hF);
			7'h4D:   g = mk_glyph(4'h9, 4'hF, 4'hD, 4'h9, 4'h9);
			7'h4E:   g = mk_glyph(4'h9, 4'hD, 4'hB, 4'h9, 4'h9);
			7'h4F:   g = mk_glyph(4'h6, 4'h9, 4'h9, 4'h9, 4'h6);
			7'h50:   g = mk_glyph(4'hE, 4'h9, 4'hE, 4'h8, 4'h8);
			7'h51:   g = mk_glyph(4'h6, 4'h9, 4'h9, 4'hA, 4'h5);
			7'h52:   g = mk_glyph(4'hE, 4'h9, 4'hE, 4'hA, 4'h9);
			7'h53:   g = mk_glyph(4'h7, 4'h8, 4'h6, 4'h1, 4'hE);
			7'h54:   g = mk_glyph(4'h7, 4'h2, 4'h2, 4'h2, 4'h2);
			7'h55:   g = mk_glyph(4'h9, 4'h9, 4'h9, 4'h9, 4'h6);
			7'h56:   g = mk_glyph(4'h9, 4'h9, 4'h9, 4'h5, 4'h2);
			7'h57:   g = mk_glyph(4'h9, 4'h9, 4'hD, 4'hF, 4'h9);
			7'h58:   g = mk_glyph(4'h9, 4'h5, 4'h2, 4'h5, 4'h9);
			7'h59:   g = mk_glyph(4'h5, 4'h5, 4'h2, 4'h2, 4'h2);
			7'h5A:   g = mk_glyph(4'hF, 4'h1, 4'h2, 4'h4, 4'hF);
			7'h3A:   g = mk_glyph(4'h0, 4'h2, 4'h0, 4'h2, 4'h0);
			7'h2F:   g = mk_glyph(4'h1, 4'h2, 4'h4, 4'h8, 4'h0);
			7'h25:   g = mk_glyph(4'h9, 4'h2, 4'h4, 4'h9, 4'h0);
			7'h2E:   g = mk_glyph(4'h0, 4'h0, 4'h0, 4'h0, 4'h2);
			7'h2B:   g = mk_glyph(4'h0, 4'h2, 4'h7, 4'h2, 4'h0);
			7'h2D:   g = mk_glyph(4'h0, 4'h0, 4'h7, 4'h0, 4'h0);
			7'h28:   g = mk_glyph(4'h2, 4'h4, 4'h4, 4'h4, 4'h2);
			7'h29:   g = mk_glyph(4'h4, 4'h2, 4'h2, 4'h2, 4'h4);
			7'h78:   g = mk_glyph(4'h0, 4'h5, 4'h2, 4'h5, 4'h0);
			7'h24:   g = mk_glyph(4'h7, 4'hA, 4'h7, 4'h2, 4'h7);
			7'h21:   g = mk_glyph(4'h2, 4'h2, 4'h2, 4'h0, 4'h2);
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/bitmap_font_text_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bitmap_font_text_rasterizer
// Draws one 4x6 font character per input beat as a run of pixel writes.
// ----------------------------------------------------------------------------
// The input beat is registered into the scanner's mask register; pixel beats
// leave through the scanner's output register. Throughput: one pixel beat per
// cycle unless m_tready stalls; s_tready is low while a character still has
// visible pixels (at most 20) left; blank or fully clipped ones emit nothing.
// Reset: pen position cleared to 0, scanner and output register empty.
module bitmap_font_text_rasterizer
	import bftr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // start_x[11:0], start_y[23:12], char_code[31:24],
	                               // pen_color[47:32]
	input  logic [1:0]  s_tuser,   // new_string[0], screen_select[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // pixel_x[7:0], pixel_y[15:8], pixel_address[31:16],
	                               // pixel_color[47:32]
	output logic        m_tuser,   // target_screen
	output logic        m_tlast    // last_pixel
);

	glyph_item_t        item;
	logic               busy;
	logic               accept;
	logic [PIX_W-1:0]   pixel_x, pixel_y;
	logic [ADDR_W-1:0]  pixel_address;
	logic [COLOR_W-1:0] pixel_color;

	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;

	bftr_glyph_mask u_mask (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.new_string    (s_tuser[0]),
		.start_x       (s_tdata[11:0]),
		.start_y       (s_tdata[23:12]),
		.char_code     (s_tdata[31:24]),
		.pen_color     (s_tdata[47:32]),
		.screen_select (s_tuser[1]),
		.item          (item)
	);

	bftr_pixel_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.item          (item),
		.busy          (busy),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.target_screen (m_tuser),
		.last_pixel    (m_tlast)
	);

	assign m_tdata = {pixel_color, pixel_address, pixel_y, pixel_x};

endmodule

// ===== rtl/bftr_glyph_mask.sv =====
// ----------------------------------------------------------------------------
// bftr_glyph_mask
// Pen registers, case folding, font lookup and on-screen clipping of one
// character into a mask of pixels to be written.
// ----------------------------------------------------------------------------
module bftr_glyph_mask
	import bftr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      new_string,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic [CODE_W-1:0]         char_code,
	input  logic [COLOR_W-1:0]        pen_color,
	input  logic                      screen_select,
	output glyph_item_t               item
);

	logic signed [COORD_W-1:0] pen_x_q, pen_y_q;
	logic signed [COORD_W-1:0] cur_x, cur_y;
	logic signed [COORD_W:0]   next_x;
	logic [CODE_W-1:0]         code;
	glyph_t                    glyph;
	logic [GLYPH_W-1:0]        col_vis;
	logic [GLYPH_H-1:0]        row_vis;
	logic signed [COORD_W:0]   cx [GLYPH_W];
	logic signed [COORD_W:0]   ry [GLYPH_H];

	assign cur_x  = new_string ? start_x : pen_x_q;
	assign cur_y  = new_string ? start_y : pen_y_q;
	assign next_x = (COORD_W+1)'(cur_x) + (COORD_W+1)'(PEN_STEP);

	always_comb begin
		code = char_code;
		if (char_code >= CodeLowA && char_code <= CodeLowZ)
			code = char_code - CaseShift;
		// high codes draw nothing
		glyph = code[CODE_W-1] ? '0 : glyph_lookup(code[CODE_W-2:0]);

		for (int c = 0; c < GLYPH_W; c++) begin
			cx[c]      = (COORD_W+1)'(cur_x) + (COORD_W+1)'(c);
			col_vis[c] = !cx[c][COORD_W] && (cx[c] < (COORD_W+1)'(SCREEN_WIDTH));
		end
		for (int r = 0; r < GLYPH_H; r++) begin
			ry[r]      = (COORD_W+1)'(cur_y) + (COORD_W+1)'(r);
			row_vis[r] = !ry[r][COORD_W] && (ry[r] < (COORD_W+1)'(SCREEN_HEIGHT));
		end

		for (int r = 0; r < GLYPH_H; r++)
			for (int c = 0; c < GLYPH_W; c++)
				item.mask[r*GLYPH_W + c] = glyph[r][GLYPH_W-1-c] & col_vis[c] & row_vis[r];

		item.base_x = cur_x;
		item.base_y = cur_y;
		item.color  = pen_color;
		item.screen = screen_select;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else if (accept) begin
			pen_x_q <= (next_x > (COORD_W+1)'(PEN_MAX)) ? COORD_W'(PEN_MAX)
				: next_x[COORD_W-1:0];
			pen_y_q <= cur_y;
		end
	end

endmodule

// ===== rtl/bftr_pixel_scan.sv =====
// ----------------------------------------------------------------------------
// bftr_pixel_scan
// Walks the pixel mask of one character, lowest bit first, and issues one
// pixel write beat per cycle through an output register when not stalled.
// ----------------------------------------------------------------------------
module bftr_pixel_scan
	import bftr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  glyph_item_t        item,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   pixel_x,
	output logic [PIX_W-1:0]   pixel_y,
	output logic [ADDR_W-1:0]  pixel_address,
	output logic [COLOR_W-1:0] pixel_color,
	output logic               target_screen,
	output logic               last_pixel
);

	logic [GLYPH_BITS-1:0]     mask_q;
	logic signed [COORD_W-1:0] base_x_q, base_y_q;
	logic [COLOR_W-1:0]        color_q;
	logic                      screen_q;
	logic                      out_valid_q;

	logic [BIT_IDX_W-1:0]      idx;
	logic [GLYPH_BITS-1:0]     hit;
	logic                      step;
	logic [COORD_W-1:0]        px_full, py_full;
	logic [VIS_W-1:0]          px, py;
	logic [31:0]               addr_full;

	always_comb begin
		idx = '0;
		for (int i = GLYPH_BITS - 1; i >= 0; i--)
			if (mask_q[i])
				idx = BIT_IDX_W'(i);
		hit = GLYPH_BITS'(1) << idx;
	end

	assign busy = (mask_q != '0);
	assign step = busy && (!out_valid_q || out_ready);

	assign px_full = base_x_q + COORD_W'(idx[COL_W-1:0]);
	assign py_full = base_y_q + COORD_W'(idx[BIT_IDX_W-1:COL_W]);
	// a drawn pixel is on screen, so its coordinates fit the narrow width
	assign px = px_full[VIS_W-1:0];
	assign py = py_full[VIS_W-1:0];
	assign addr_full = 32'(py) * 32'(SCREEN_WIDTH) + 32'(px);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				mask_q <= item.mask;
			else if (step)
				mask_q <= mask_q & ~hit;
			if (step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			base_x_q <= item.base_x;
			base_y_q <= item.base_y;
			color_q  <= item.color;
			screen_q <= item.screen;
		end
		if (step) begin
			pixel_x       <= px[PIX_W-1:0];
			pixel_y       <= py[PIX_W-1:0];
			pixel_address <= addr_full[ADDR_W-1:0];
			pixel_color   <= color_q;
			target_screen <= screen_q;
			last_pixel    <= ((mask_q & ~hit) == '0);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 4x6 text rasterizer: a directed table of
// characters and then random strings go in as stream beats. A behavioral pen
// and font model, or a dot given in the table, predicts each pixel beat; each
// output beat is checked against the oldest. Sides idle at random, bar a calm run.
// ----------------------------------------------------------------------------
module tb;
	import bftr_pkg::*;

	localparam int QUIET_LIMIT  = 3000;
	localparam int RANDOM_CHARS = 106;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_PCT     = 29;
	localparam logic [CODE_W-1:0] HIGH_CODE = 8'h80;
	localparam logic [CODE_W-1:0] TOP_CODE  = 8'hFF;
	localparam logic [CODE_W-1:0] NUL_CODE  = 8'h00;
	localparam logic [CODE_W-1:0] DEL_CODE  = 8'h7F;

	typedef enum {BY_MODEL, ONE_DOT, NO_DOTS} check_mode_t;

	typedef struct {
		logic                      new_string;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic [CODE_W-1:0]         code;
		logic [COLOR_W-1:0]        color;
		logic                      screen;
		check_mode_t               mode;
		logic [PIX_W-1:0]          ex;
		logic [PIX_W-1:0]          ey;
		logic [ADDR_W-1:0]         eaddr;
	} char_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               screen;
		logic               last;
	} pixel_write_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;   // start_x, start_y, char_code, pen_color
	logic [1:0]  s_tuser  = '0;   // new_string, screen_select
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // pixel_x, pixel_y, pixel_address, pixel_color
	logic        m_tuser;         // target_screen
	logic        m_tlast;         // last_pixel

	pixel_write_t pending_writes[$];
	char_beat_t   directed[$];
	int           pen_col = 0;
	int           pen_row = 0;
	int           mismatches = 0;
	int           quiet_cycles = 0;
	logic         calm = 1'b0;
	string        glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ:/%.+-()$!x";

	bitmap_font_text_rasterizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	// Rows 0..4 of a glyph, row 0 in the top nibble, bit 3 of a nibble leftmost.
	// Row 5 is blank for every glyph.
	function automatic logic [19:0] font_rows(input logic [CODE_W-1:0] c);
		case (c)
			"0": return 20'h69996;
			"1": return 20'h26227;
			"2": return 20'h6924F;
			"3": return 20'hE161E;
			"4": return 20'h99F11;
			"5": return 20'hF8E1E;
			"6": return 20'h68E96;
			"7": return 20'hF1244;
			"8": return 20'h69696;
			"9": return 20'h69716;
			"A": return 20'h69F99;
			"B": return 20'hE9E9E;
			"C": return 20'h78887;
			"D": return 20'hE999E;
			"E": return 20'hF8E8F;
			"F": return 20'hF8E88;
			"G": return 20'h78B97;
			"H": return 20'h99F99;
			"I": return 20'h72227;
			"J": return 20'h11196;
			"K": return 20'h9ACA9;
			"L": return 20'h8888F;
			"M": return 20'h9FD99;
			"N": return 20'h9DB99;
			"O": return 20'h69996;
			"P": return 20'hE9E88;
			"Q": return 20'h699A5;
			"R": return 20'hE9EA9;
			"S": return 20'h7861E;
			"T": return 20'h72222;
			"U": return 20'h99996;
			"V": return 20'h99952;
			"W": return 20'h99DF9;
			"X": return 20'h95259;
			"Y": return 20'h55222;
			"Z": return 20'hF124F;
			":": return 20'h02020;
			"/": return 20'h12480;
			"%": return 20'h92490;
			".": return 20'h00002;
			"+": return 20'h02720;
			"-": return 20'h00700;
			"(": return 20'h24442;
			")": return 20'h42224;
			"x": return 20'h05250;
			"$": return 20'h7A727;
			"!": return 20'h22202;
			default: return 20'h0;
		endcase
	endfunction

	// Advances the pen and queues the pixel beats one character should cause.
	function automatic void accept_char(input char_beat_t r);
		logic [CODE_W-1:0] c;
		logic [19:0]       rows;
		int                px;
		int                py;
		pixel_write_t      w;
		pixel_write_t      dots[$];
		if (r.new_string) begin
			pen_col = r.sx;
			pen_row = r.sy;
		end
		c = r.code;
		if (c >= CodeLowA && c <= CodeLowZ)
			c = c - CaseShift;
		rows = (c < HIGH_CODE) ? font_rows(c) : 20'h0;
		for (int row = 0; row < GLYPH_H - 1; row++) begin
			for (int col = 0; col < GLYPH_W; col++) begin
				px = pen_col + col;
				py = pen_row + row;
				if (rows[19 - 4 * row - col] && px >= 0 && px < SCREEN_WIDTH &&
						py >= 0 && py < SCREEN_HEIGHT) begin
					w.x      = px[PIX_W-1:0];
					w.y      = py[PIX_W-1:0];
					w.addr   = ADDR_W'(py * SCREEN_WIDTH + px);
					w.color  = r.color;
					w.screen = r.screen;
					w.last   = 1'b0;
					dots.push_back(w);
				end
			end
		end
		if (dots.size() > 0)
			dots[dots.size() - 1].last = 1'b1;
		pen_col = (pen_col + PEN_STEP > PEN_MAX) ? PEN_MAX : pen_col + PEN_STEP;

		case (r.mode)
			BY_MODEL: begin
				foreach (dots[k])
					pending_writes.push_back(dots[k]);
			end
			ONE_DOT: begin
				w.x      = r.ex;
				w.y      = r.ey;
				w.addr   = r.eaddr;
				w.color  = r.color;
				w.screen = r.screen;
				w.last   = 1'b1;
				pending_writes.push_back(w);
			end
			default: ;
		endcase
	endfunction

	task automatic add_row(input logic ns, input int sx, input int sy,
			input logic [CODE_W-1:0] code, input logic [COLOR_W-1:0] color,
			input logic screen, input check_mode_t mode,
			input int ex = 0, input int ey = 0, input int eaddr = 0);
		char_beat_t r;
		r.new_string = ns;
		r.sx         = sx[COORD_W-1:0];
		r.sy         = sy[COORD_W-1:0];
		r.code       = code;
		r.color      = color;
		r.screen     = screen;
		r.mode       = mode;
		r.ex         = ex[PIX_W-1:0];
		r.ey         = ey[PIX_W-1:0];
		r.eaddr      = eaddr[ADDR_W-1:0];
		directed.push_back(r);
	endtask

	function automatic char_beat_t random_char();
		char_beat_t r;
		int         pick;
		r.new_string = ($urandom_range(7) == 0);
		if ($urandom_range(99) < 35) begin
			r.sx = $urandom;
			r.sy = $urandom;
		end else begin
			r.sx = $urandom_range(264) - 6;
			r.sy = $urandom_range(200) - 6;
		end
		pick = $urandom_range(99);
		if (pick < 70) begin
			r.code = glyph_chars[$urandom_range(glyph_chars.len() - 1)];
			if (r.code >= "A" && r.code <= "Z" && $urandom_range(3) == 0)
				r.code = r.code + CaseShift;
		end else if (pick < 85) begin
			r.code = CodeLowA + $urandom_range(25);
		end else begin
			r.code = $urandom_range(255);
		end
		r.color  = $urandom;
		r.screen = $urandom_range(1);
		r.mode   = BY_MODEL;
		r.ex     = '0;
		r.ey     = '0;
		r.eaddr  = '0;
		return r;
	endfunction

	task automatic drive_char(input char_beat_t r);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.color, r.code, r.sy, r.sx};
		s_tuser  <= {r.screen, r.new_string};
		do @(posedge clk); while (!s_tready);
		accept_char(r);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		pixel_write_t want;
		pixel_write_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[7:0], m_tdata[15:8], m_tdata[31:16], m_tdata[47:32],
				m_tuser, m_tlast};
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected pixel beat, expected none, actual %h", $time, got);
				mismatches++;
			end else begin
				want = pending_writes.pop_front();
				check_field("pixel_x", want.x, got.x);
				check_field("pixel_y", want.y, got.y);
				check_field("pixel_address", want.addr, got.addr);
				check_field("pixel_color", want.color, got.color);
				check_field("target_screen", want.screen, got.screen);
				check_field("last_pixel", want.last, got.last);
			end
		end
	end

	// Nothing moving on either side for too long means the block hung.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("[bitmap_font_text_rasterizer] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// pen at 0,0 after reset; dot sits at column 2, row 4
		add_row(0, 0, 0, ".", 16'hFFFF, 1, ONE_DOT, 2, 4, 1026);
		add_row(0, 0, 0, ".", 16'h0000, 0, ONE_DOT, 7, 4, 1031);
		add_row(1, 0, 0, "8", 16'h1234, 0, BY_MODEL);
		add_row(0, 0, 0, "W", 16'hBEEF, 1, BY_MODEL);
		add_row(0, 0, 0, "a", 16'h0F0F, 0, BY_MODEL);
		add_row(0, 0, 0, "z", 16'hF0F0, 1, BY_MODEL);
		add_row(0, 0, 0, "x", 16'h8001, 0, BY_MODEL);
		add_row(0, 0, 0, HIGH_CODE, 16'hFFFF, 1, NO_DOTS);
		add_row(0, 0, 0, TOP_CODE, 16'hFFFF, 1, NO_DOTS);
		add_row(0, 0, 0, "#", 16'hFFFF, 1, NO_DOTS);
		add_row(0, 0, 0, NUL_CODE, 16'hFFFF, 1, NO_DOTS);
		add_row(0, 0, 0, DEL_CODE, 16'hFFFF, 1, NO_DOTS);
		add_row(1, -2048, -2048, "M", 16'h1111, 0, NO_DOTS);
		// pen saturates at the right edge of the coordinate range
		add_row(1, 2047, 2047, "8", 16'h2222, 1, NO_DOTS);
		add_row(0, 0, 0, "8", 16'h3333, 0, NO_DOTS);
		add_row(1, 253, 187, ".", 16'h4444, 1, ONE_DOT, 255, 191, 49151);
		add_row(1, 252, 187, ".", 16'h5555, 0, ONE_DOT, 254, 191, 49150);
		add_row(1, -2, 0, "8", 16'h6666, 1, BY_MODEL);
		add_row(1, 253, 188, "M", 16'h7777, 0, BY_MODEL);
		add_row(1, -4, 0, ".", 16'h8888, 1, NO_DOTS);
		add_row(1, 0, -4, "8", 16'h9999, 0, BY_MODEL);
		add_row(1, 100, 50, "$", 16'hAAAA, 1, BY_MODEL);
		add_row(0, 0, 0, "!", 16'h5555, 0, BY_MODEL);
		add_row(0, 0, 0, "%", 16'hC3C3, 1, BY_MODEL);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[k])
			drive_char(directed[k]);
		for (int i = 0; i < RANDOM_CHARS; i++) begin
			calm = (i >= 50 && i < 85);
			drive_char(random_char());
		end
		calm = 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[bitmap_font_text_rasterizer] OK");
		else
			$display("[bitmap_font_text_rasterizer] ERROR");
		$finish;
	end

endmodule
